// ===== rtl/dpfr_pkg.sv =====
// Shared constants and control/status types of the demand page fault resolver.
`timescale 1ns / 1ps
`default_nettype none

package dpfr_pkg;

    localparam int PAGE_BITS        = 12;
    localparam int PAGE_BYTES       = 1 << PAGE_BITS;
    localparam int ADDR_W           = 32;
    localparam int END_W            = ADDR_W + 1;
    localparam int PAGE_NUM_W       = END_W - PAGE_BITS;
    localparam int NSEG_W           = 5;
    localparam int SEGIDX_W         = 4;
    localparam int PERM_W           = 3;
    localparam int CNT_W            = 32;
    localparam int POFF_W           = PAGE_BITS;
    localparam int BYTES_W          = PAGE_BITS + 1;
    localparam int S_TDATA_W        = 168;
    localparam int M_TDATA_W        = 168;
    localparam int DEF_MAX_SEGMENTS = 16;

    // request kinds carried in s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FAULT = 1'b1;

    typedef struct packed {
        logic capture;     // latch the accepted input item
        logic wr_entry;    // store the held segment entry
        logic scan_start;  // reset scan index, prepare page end
        logic scan_next;   // advance scan index
        logic calc1;       // clip file/segment span to the page
        logic calc2;       // byte counts and copy offset
        logic out_hit;     // load result register with a hit
        logic out_miss;    // load result register with a miss
    } dpfr_cmd_t;

    typedef struct packed {
        logic scan_match;
        logic scan_last;
        logic scan_empty;
        logic out_free;
    } dpfr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dpfr_ctrl.sv =====
// Controller state machine of the demand page fault resolver.
`timescale 1ns / 1ps
`default_nettype none

module dpfr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 req_type,
    output logic                      s_tready,
    input  wire dpfr_pkg::dpfr_stat_t stat,
    output dpfr_pkg::dpfr_cmd_t       cmd
);
    import dpfr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_CALC1,
        ST_CALC2,
        ST_HIT,
        ST_MISS
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept   = s_tvalid && ready_reg;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    ready_next  = 1'b0;
                    state_next  = (req_type == REQ_WRITE) ? ST_WRITE : ST_SCAN_INIT;
                end
            end
            ST_WRITE: begin
                cmd.wr_entry = 1'b1;
                ready_next   = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCAN_INIT: begin
                cmd.scan_start = 1'b1;
                state_next     = stat.scan_empty ? ST_MISS : ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.scan_match) begin
                    state_next = ST_CALC1;
                end else if (stat.scan_last) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_CALC1: begin
                cmd.calc1  = 1'b1;
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                cmd.calc2  = 1'b1;
                state_next = ST_HIT;
            end
            ST_HIT: begin
                if (stat.out_free) begin
                    cmd.out_hit = 1'b1;
                    ready_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (stat.out_free) begin
                    cmd.out_miss = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dpfr_datapath.sv =====
// Datapath of the demand page fault resolver: segment table, scan compare, page math.
`timescale 1ns / 1ps
`default_nettype none

module dpfr_datapath #(
    parameter int MAX_SEGMENTS = dpfr_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dpfr_pkg::NSEG_W-1:0]     cfg_wr_data,
    input  wire logic [dpfr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire dpfr_pkg::dpfr_cmd_t             cmd,
    output dpfr_pkg::dpfr_stat_t                 stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dpfr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                           m_tuser
);
    import dpfr_pkg::*;

    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LIMB_W = $clog2(MAX_SEGMENTS + 1);
    localparam int LIM_W  = (LIMB_W > NSEG_W) ? LIMB_W : NSEG_W;

    // held input item
    logic [SEGIDX_W-1:0] seg_index_reg;
    logic                seg_is_load_reg;
    logic [ADDR_W-1:0]   seg_vaddr_reg;
    logic [ADDR_W-1:0]   seg_mem_size_reg;
    logic [ADDR_W-1:0]   seg_file_size_reg;
    logic [ADDR_W-1:0]   seg_file_offset_reg;
    logic [PERM_W-1:0]   seg_perm_reg;
    logic [ADDR_W-1:0]   flt_va_reg;

    // segment table: start, memory end, file end, file offset minus start, permissions
    logic [ADDR_W-1:0]       start_mem [MAX_SEGMENTS];
    logic [END_W-1:0]        end_mem   [MAX_SEGMENTS];
    logic [END_W-1:0]        fend_mem  [MAX_SEGMENTS];
    logic [ADDR_W-1:0]       fos_mem   [MAX_SEGMENTS];
    logic [PERM_W-1:0]       perm_mem  [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] load_vld_reg;

    logic [NSEG_W-1:0] num_seg_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [END_W-1:0]  page_end_reg;
    logic [ADDR_W-1:0] fb_start_reg;
    logic [END_W-1:0]  fb_end_reg;
    logic [END_W-1:0]  tail_end_reg;
    logic [END_W-1:0]  tail_begin_reg;
    logic [BYTES_W-1:0] nbytes_reg;
    logic [ADDR_W-1:0] cfo_reg;

    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;
    logic                    m_hit_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // registered table read, addressed with the scan index it will hold
    logic [IDX_W-1:0]  rd_addr;
    logic [ADDR_W-1:0] rd_start_reg;
    logic [END_W-1:0]  rd_end_reg;
    logic [END_W-1:0]  rd_fend_reg;
    logic [ADDR_W-1:0] rd_fos_reg;
    logic [PERM_W-1:0] rd_perm_reg;

    // table read at the scan index
    logic [ADDR_W-1:0] rd_start;
    logic [END_W-1:0]  rd_end;
    logic [END_W-1:0]  rd_fend;
    logic [ADDR_W-1:0] rd_fos;
    logic [PERM_W-1:0] rd_perm;
    logic              rd_load;

    logic [IDX_W-1:0]  wr_idx;
    logic              wr_in_range;
    logic [LIM_W-1:0]  nseg_ext;
    logic [LIM_W-1:0]  limit;
    logic [END_W-1:0]  pg_base;
    logic [PAGE_NUM_W-1:0] fault_page;
    logic              addr_ge;
    logic              addr_lt;
    logic [CNT_W-1:0]  cnt_inc;
    logic [POFF_W-1:0] head_zero;
    logic [POFF_W-1:0] cpo_out;
    logic [ADDR_W-1:0] cfo_out;
    logic [BYTES_W-1:0] tzo_out;
    logic [BYTES_W-1:0] tzb_out;
    logic [PERM_W-1:0] perm_out;
    logic [3:0]        match_idx;

    assign rd_addr = cmd.scan_start ? '0 :
                     cmd.scan_next  ? idx_reg + IDX_W'(1) : idx_reg;

    always_ff @(posedge aclk) begin
        rd_start_reg <= start_mem[rd_addr];
        rd_end_reg   <= end_mem[rd_addr];
        rd_fend_reg  <= fend_mem[rd_addr];
        rd_fos_reg   <= fos_mem[rd_addr];
        rd_perm_reg  <= perm_mem[rd_addr];
    end

    assign rd_start = rd_start_reg;
    assign rd_end   = rd_end_reg;
    assign rd_fend  = rd_fend_reg;
    assign rd_fos   = rd_fos_reg;
    assign rd_perm  = rd_perm_reg;
    assign rd_load  = load_vld_reg[idx_reg];

    assign wr_idx      = IDX_W'(seg_index_reg);
    assign wr_in_range = int'(seg_index_reg) < MAX_SEGMENTS;

    assign nseg_ext = LIM_W'(num_seg_reg);
    assign limit    = (nseg_ext > LIM_W'(MAX_SEGMENTS)) ? LIM_W'(MAX_SEGMENTS) : nseg_ext;

    assign fault_page = {1'b0, flt_va_reg[ADDR_W-1:PAGE_BITS]};
    assign pg_base    = {fault_page, {PAGE_BITS{1'b0}}};

    // address below the page-rounded segment end, no adder needed
    assign addr_ge = flt_va_reg >= rd_start;
    assign addr_lt = (fault_page < rd_end[END_W-1:PAGE_BITS]) ||
                     ((fault_page == rd_end[END_W-1:PAGE_BITS]) &&
                      (rd_end[PAGE_BITS-1:0] != '0));

    assign stat.scan_match = rd_load && addr_ge && addr_lt;
    assign stat.scan_last  = (LIM_W'(idx_reg) + LIM_W'(1)) >= limit;
    assign stat.scan_empty = (limit == '0);
    assign stat.out_free   = !m_valid_reg || m_tready;

    // input capture and write path
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            seg_index_reg       <= s_tdata[3:0];
            seg_is_load_reg     <= s_tdata[4];
            seg_vaddr_reg       <= s_tdata[36:5];
            seg_mem_size_reg    <= s_tdata[68:37];
            seg_file_size_reg   <= s_tdata[100:69];
            seg_file_offset_reg <= s_tdata[132:101];
            seg_perm_reg        <= s_tdata[135:133];
            flt_va_reg          <= s_tdata[167:136];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_entry && wr_in_range) begin
            start_mem[wr_idx] <= seg_vaddr_reg;
            end_mem[wr_idx]   <= {1'b0, seg_vaddr_reg} + {1'b0, seg_mem_size_reg};
            fend_mem[wr_idx]  <= {1'b0, seg_vaddr_reg} + {1'b0, seg_file_size_reg};
            fos_mem[wr_idx]   <= seg_file_offset_reg - seg_vaddr_reg;
            perm_mem[wr_idx]  <= seg_perm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_vld_reg <= '0;
            num_seg_reg  <= '0;
            idx_reg      <= '0;
        end else begin
            if (cmd.wr_entry && wr_in_range) begin
                load_vld_reg[wr_idx] <= seg_is_load_reg;
            end
            if (cfg_wr_en) begin
                num_seg_reg <= cfg_wr_data;
            end
            if (cmd.scan_start) begin
                idx_reg <= '0;
            end else if (cmd.scan_next) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // page math: page end at scan start, then the calc1 and calc2 steps
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            page_end_reg <= {fault_page + PAGE_NUM_W'(1), {PAGE_BITS{1'b0}}};
        end
        if (cmd.calc1) begin
            fb_start_reg <= (rd_start > pg_base[ADDR_W-1:0]) ? rd_start
                                                             : pg_base[ADDR_W-1:0];
            fb_end_reg   <= (page_end_reg <= rd_fend) ? page_end_reg : rd_fend;
            tail_end_reg <= (page_end_reg <= rd_end) ? page_end_reg : rd_end;
        end
        if (cmd.calc2) begin
            nbytes_reg     <= (fb_end_reg > {1'b0, fb_start_reg})
                              ? BYTES_W'(fb_end_reg - {1'b0, fb_start_reg}) : '0;
            cfo_reg        <= rd_fos + fb_start_reg;
            tail_begin_reg <= (fb_end_reg > pg_base) ? fb_end_reg : pg_base;
        end
    end

    assign head_zero = fb_start_reg[POFF_W-1:0];
    assign cpo_out   = (nbytes_reg != '0) ? head_zero : '0;
    assign cfo_out   = (nbytes_reg != '0) ? cfo_reg : '0;
    assign tzo_out   = (tail_end_reg > tail_begin_reg)
                       ? BYTES_W'(tail_begin_reg - pg_base) : '0;
    assign tzb_out   = (tail_end_reg > tail_begin_reg)
                       ? BYTES_W'(tail_end_reg - tail_begin_reg) : '0;
    // stored {read, write, execute} -> output {execute, write, read}
    assign perm_out  = {rd_perm[0], rd_perm[1], rd_perm[2]};
    assign match_idx = 4'(idx_reg);
    assign cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1);

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_hit) begin
            m_hit_reg  <= 1'b1;
            m_data_reg <= {2'b00, cnt_inc, tzb_out, tzo_out, head_zero, nbytes_reg,
                           cpo_out, cfo_out, perm_out, pg_base[ADDR_W-1:0], match_idx};
        end else if (cmd.out_miss) begin
            m_hit_reg  <= 1'b0;
            m_data_reg <= {2'b00, cnt_reg, {(M_TDATA_W - 2 - CNT_W){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (cmd.out_hit || cmd.out_miss) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.out_hit) begin
                cnt_reg <= cnt_inc;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_hit_reg;

endmodule

`default_nettype wire

// ===== rtl/demand_page_fault_resolver_core.sv =====
// Top level of the demand page fault resolver.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata segment entry + fault address, s_tuser request kind
//  m_       out  m_tvalid/m_tready    m_tdata page fill description, m_tuser hit flag
//  cfg      in   cfg_wr_en            cfg_wr_data number of segments searched
//
// A segment write passes through the write state. A fault passes through scan init and a table
// scan (one compare per entry visited, up to num_segments), then on a hit through the page-math
// states CALC1 and CALC2, before the result register loads. A miss loads it after the scan.
// The result register frees the input side: a new item is taken while a result waits.
// A stalled m_tready holds a finished result in its final state until the register frees.
// Reset clears the load flags, the search length and the page counter.
`timescale 1ns / 1ps
`default_nettype none

module demand_page_fault_resolver_core #(
    parameter int MAX_SEGMENTS = dpfr_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dpfr_pkg::NSEG_W-1:0]    cfg_wr_data,  // num_segments
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // seg_index[3:0], seg_is_load[4], seg_vaddr[36:5], seg_mem_size[68:37],
    // seg_file_size[100:69], seg_file_offset[132:101], seg_perm[135:133],
    // fault_va[167:136]
    input  wire logic [dpfr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]                     s_tuser,      // req_type[0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // matched_segment[3:0], page_base[35:4], page_perm[38:36],
    // copy_file_offset[70:39], copy_page_offset[82:71], copy_bytes[95:83],
    // head_zero_bytes[107:96], tail_zero_offset[120:108], tail_zero_bytes[133:121],
    // pages_mapped[165:134], zero pad[167:166]
    output logic [dpfr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser       // hit[0]
);
    import dpfr_pkg::*;

    dpfr_cmd_t  cmd;
    dpfr_stat_t stat;

    dpfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpfr_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a segment write retires through the write state and raises s_tready again
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == REQ_WRITE) |=> ##1 s_tready)
        else $error("segment write did not retire");

    // a miss carries nothing but the page count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[133:0] == '0))
        else $error("miss result has nonzero fields");

    // the page counter only moves on a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.out_hit |=> $stable(u_datapath.cnt_reg))
        else $error("page counter changed without a hit");

endmodule

`default_nettype wire

// ===== test/tb_demand_page_fault_resolver_core.sv =====
// Self-checking testbench for the demand page fault resolver: directed table, then random phases.
`timescale 1ns / 1ps

module tb_demand_page_fault_resolver_core;

    import dpfr_pkg::*;

    localparam int          MAX_SEG       = DEF_MAX_SEGMENTS;
    localparam bit [63:0]   PAGE_MASK     = ~64'(PAGE_BYTES - 1);
    localparam int          SETTLE_CYCLES = 32;   // longest fault walk plus page math, rounded up
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 85;

    // s_tdata layout, lowest bits last
    typedef struct packed {
        logic [31:0] fault_va;
        logic [2:0]  perm;          // bit0 exec, bit1 write, bit2 read
        logic [31:0] file_off;
        logic [31:0] file_size;
        logic [31:0] mem_size;
        logic [31:0] vaddr;
        logic        is_load;
        logic [3:0]  index;
    } seg_req_t;

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] pages_mapped;
        logic [12:0] tail_zero_bytes;
        logic [12:0] tail_zero_offset;
        logic [11:0] head_zero_bytes;
        logic [12:0] copy_bytes;
        logic [11:0] copy_page_offset;
        logic [31:0] copy_file_offset;
        logic [2:0]  page_perm;     // bit0 read, bit1 write, bit2 exec
        logic [31:0] page_base;
        logic [3:0]  matched_segment;
    } fill_plan_t;

    typedef struct packed {
        logic       hit;
        fill_plan_t plan;
    } fault_reply_t;

    typedef enum {STEP_REQ, STEP_SETLEN} step_kind_t;

    typedef struct {
        step_kind_t   kind;
        logic         req;
        seg_req_t     body;
        logic [4:0]   setlen;
        bit           typed;
        fault_reply_t reply;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [NSEG_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;  // index, is_load, vaddr, mem_size, file_size, file_off,
                                     // perm, fault_va
    logic [0:0]            s_tuser;  // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;  // matched_segment, page_base, page_perm, copy_file_offset,
                                     // copy_page_offset, copy_bytes, head_zero_bytes,
                                     // tail_zero_offset, tail_zero_bytes, pages_mapped, pad
    logic [0:0]            m_tuser;  // hit

    // predictor state
    seg_req_t     seg_tab [MAX_SEG];
    logic [4:0]   search_len;
    logic [31:0]  faults_resolved;
    fault_reply_t fill_plans_due[$];

    int mismatches;
    bit quiet;
    int holds_wanted;
    int holds_served;

    demand_page_fault_resolver_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("tb_demand_page_fault_resolver_core failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // First loadable entry whose page-rounded span holds the address wins.
    function automatic fault_reply_t resolve_fault(input logic [31:0] addr);
        fault_reply_t r;
        int           i;
        int           limit;
        bit [63:0]    a64, start, seg_end, seg_pend, pg_lo, pg_hi, file_end;
        bit [63:0]    fb_lo, fb_hi, nbytes, zb_lo, zb_hi;
        r = '0;
        r.plan.pages_mapped = faults_resolved;
        a64 = {32'd0, addr};
        limit = (search_len > MAX_SEG) ? MAX_SEG : int'(search_len);
        for (i = 0; i < limit && !r.hit; i++) begin
            if (seg_tab[i].is_load) begin
                start    = seg_tab[i].vaddr;
                seg_end  = start + seg_tab[i].mem_size;
                seg_pend = (seg_end + PAGE_BYTES - 1) & PAGE_MASK;
                if (a64 >= start && a64 < seg_pend) begin
                    pg_lo    = a64 & PAGE_MASK;
                    pg_hi    = pg_lo + PAGE_BYTES;
                    file_end = start + seg_tab[i].file_size;
                    fb_lo    = (pg_lo < start) ? start : pg_lo;
                    fb_hi    = (pg_hi <= file_end) ? pg_hi : file_end;
                    nbytes   = (fb_hi > fb_lo) ? fb_hi - fb_lo : 64'd0;
                    zb_lo    = (fb_hi > pg_lo) ? fb_hi : pg_lo;
                    zb_hi    = (pg_hi <= seg_end) ? pg_hi : seg_end;
                    if (faults_resolved != 32'hFFFF_FFFF)
                        faults_resolved++;
                    r.hit                  = 1'b1;
                    r.plan.matched_segment = i[3:0];
                    r.plan.page_base       = pg_lo[31:0];
                    r.plan.page_perm       = {seg_tab[i].perm[0], seg_tab[i].perm[1],
                                              seg_tab[i].perm[2]};
                    if (nbytes != 0) begin
                        r.plan.copy_file_offset = 32'(seg_tab[i].file_off + fb_lo - start);
                        r.plan.copy_page_offset = 12'(fb_lo - pg_lo);
                    end
                    r.plan.copy_bytes      = 13'(nbytes);
                    r.plan.head_zero_bytes = 12'(fb_lo - pg_lo);
                    if (zb_hi > zb_lo) begin
                        r.plan.tail_zero_offset = 13'(zb_lo - pg_lo);
                        r.plan.tail_zero_bytes  = 13'(zb_hi - zb_lo);
                    end
                    r.plan.pages_mapped = faults_resolved;
                end
            end
        end
        return r;
    endfunction

    // Pick an address inside a searchable loaded segment, biased to its edges; any address if none.
    function automatic logic [31:0] aim_address();
        int        choices[$];
        int        i;
        int        limit;
        bit [63:0] start, seg_end, pend, file_end, span, a;
        limit = (search_len > MAX_SEG) ? MAX_SEG : int'(search_len);
        for (i = 0; i < limit; i++)
            if (seg_tab[i].is_load)
                choices.push_back(i);
        if (choices.size() == 0)
            return $urandom;
        i        = choices[$urandom_range(choices.size() - 1)];
        start    = seg_tab[i].vaddr;
        seg_end  = start + seg_tab[i].mem_size;
        pend     = (seg_end + PAGE_BYTES - 1) & PAGE_MASK;
        file_end = start + seg_tab[i].file_size;
        span     = pend - start;
        if (span == 0)
            return start[31:0];
        case ($urandom_range(5))
            0: a = start;
            1: a = pend - 1;
            2: a = file_end - 1 + $urandom_range(2);
            3: a = seg_end - 1 + $urandom_range(2);
            4: a = ((start + {$urandom, $urandom} % span) & PAGE_MASK) + $urandom_range(1);
            default: a = start + {$urandom, $urandom} % span;
        endcase
        if (a[63:32] != 0)
            a = 64'hFFFF_FFFF;
        if (a < start || a >= pend)
            a = start;
        return a[31:0];
    endfunction

    function automatic seg_req_t shape_segment(input seg_req_t b);
        int pick;
        b.is_load = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 10)
            b.vaddr = 32'hFFFF_0000 | $urandom_range(32'hFFFF);
        else if (pick < 20)
            b.vaddr = $urandom_range(32'h3FFF);
        b.mem_size = ($urandom_range(99) < 8) ? $urandom : $urandom_range(32'h6000);
        pick = $urandom_range(99);
        if (pick < 15)
            b.file_size = 32'd0;
        else if (pick < 30)
            b.file_size = b.mem_size + $urandom_range(32'h2000);  // file longer than memory
        else if (pick < 35)
            b.file_size = $urandom;
        else
            b.file_size = $urandom_range(b.mem_size);
        return b;
    endfunction

    function automatic stim_row_t blank_row(input step_kind_t kind);
        stim_row_t r;
        r.kind   = kind;
        r.req    = REQ_FAULT;
        r.body   = '0;
        r.setlen = '0;
        r.typed  = 1'b0;
        r.reply  = '0;
        return r;
    endfunction

    function automatic stim_row_t seg_row(input int idx, input bit load, input logic [31:0] va,
                                          input logic [31:0] ms, input logic [31:0] fs,
                                          input logic [31:0] fo, input logic [2:0] pm);
        stim_row_t r;
        r = blank_row(STEP_REQ);
        r.req            = REQ_WRITE;
        r.body.index     = idx[3:0];
        r.body.is_load   = load;
        r.body.vaddr     = va;
        r.body.mem_size  = ms;
        r.body.file_size = fs;
        r.body.file_off  = fo;
        r.body.perm      = pm;
        return r;
    endfunction

    function automatic stim_row_t fault_row(input logic [31:0] addr);
        stim_row_t r;
        r = blank_row(STEP_REQ);
        r.body.fault_va = addr;
        return r;
    endfunction

    function automatic stim_row_t fault_typed(input logic [31:0] addr, input bit hit,
                                              input logic [3:0] seg, input logic [2:0] pm,
                                              input logic [31:0] cfo, input logic [11:0] cpo,
                                              input logic [12:0] nbytes, input logic [11:0] head,
                                              input logic [12:0] tzo, input logic [12:0] tzb,
                                              input logic [31:0] pages);
        stim_row_t r;
        r = fault_row(addr);
        r.typed                       = 1'b1;
        r.reply.hit                   = hit;
        r.reply.plan.matched_segment  = seg;
        r.reply.plan.page_base        = hit ? (addr & 32'hFFFF_F000) : 32'd0;
        r.reply.plan.page_perm        = pm;
        r.reply.plan.copy_file_offset = cfo;
        r.reply.plan.copy_page_offset = cpo;
        r.reply.plan.copy_bytes       = nbytes;
        r.reply.plan.head_zero_bytes  = head;
        r.reply.plan.tail_zero_offset = tzo;
        r.reply.plan.tail_zero_bytes  = tzb;
        r.reply.plan.pages_mapped     = pages;
        return r;
    endfunction

    function automatic stim_row_t setlen_row(input int n);
        stim_row_t r;
        r = blank_row(STEP_SETLEN);
        r.setlen = n[4:0];
        return r;
    endfunction

    task automatic drain_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (fill_plans_due.size() != 0)
            @(posedge aclk);
    endtask

    // Writes land only while the block is empty; a trailing segment write gets time to finish.
    task automatic set_search_len(input logic [4:0] n);
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        search_len = n;
    endtask

    task automatic issue(input stim_row_t row);
        fault_reply_t reply;
        while (!quiet && $urandom_range(99) < 17) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= row.body;
        s_tuser  <= row.req;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (row.req == REQ_WRITE) begin
            seg_tab[row.body.index] = row.body;
        end else begin
            reply = resolve_fault(row.body.fault_va);
            fill_plans_due.push_back(row.typed ? row.reply : reply);
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != holds_wanted) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= (quiet || $urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge aclk) begin
        fault_reply_t want;
        fill_plan_t   got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (fill_plans_due.size() == 0) begin
                report_mismatch("unexpected result transfer", m_tdata[63:0], 64'd0);
            end else begin
                want = fill_plans_due.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", m_tuser, want.hit);
                if (got.matched_segment !== want.plan.matched_segment)
                    report_mismatch("matched_segment", got.matched_segment,
                                    want.plan.matched_segment);
                if (got.page_base !== want.plan.page_base)
                    report_mismatch("page_base", got.page_base, want.plan.page_base);
                if (got.page_perm !== want.plan.page_perm)
                    report_mismatch("page_perm", got.page_perm, want.plan.page_perm);
                if (got.copy_file_offset !== want.plan.copy_file_offset)
                    report_mismatch("copy_file_offset", got.copy_file_offset,
                                    want.plan.copy_file_offset);
                if (got.copy_page_offset !== want.plan.copy_page_offset)
                    report_mismatch("copy_page_offset", got.copy_page_offset,
                                    want.plan.copy_page_offset);
                if (got.copy_bytes !== want.plan.copy_bytes)
                    report_mismatch("copy_bytes", got.copy_bytes, want.plan.copy_bytes);
                if (got.head_zero_bytes !== want.plan.head_zero_bytes)
                    report_mismatch("head_zero_bytes", got.head_zero_bytes,
                                    want.plan.head_zero_bytes);
                if (got.tail_zero_offset !== want.plan.tail_zero_offset)
                    report_mismatch("tail_zero_offset", got.tail_zero_offset,
                                    want.plan.tail_zero_offset);
                if (got.tail_zero_bytes !== want.plan.tail_zero_bytes)
                    report_mismatch("tail_zero_bytes", got.tail_zero_bytes,
                                    want.plan.tail_zero_bytes);
                if (got.pages_mapped !== want.plan.pages_mapped)
                    report_mismatch("pages_mapped", got.pages_mapped, want.plan.pages_mapped);
            end
        end
    end

    initial begin
        stim_row_t  script[$];
        stim_row_t  row;
        int         phase;
        int         n;
        int         pick;
        logic [4:0] len_plan [PHASES];

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        quiet       = 1'b0;
        mismatches  = 0;
        holds_wanted = 0;
        holds_served = 0;
        search_len      = '0;
        faults_resolved = '0;
        foreach (seg_tab[i])
            seg_tab[i] = '0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // misses while the search length is still zero
        script.push_back(fault_typed(32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(fault_typed(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(seg_row(0, 1, 32'h0000_1000, 32'h3000, 32'h1800, 32'h200, 3'b111));
        script.push_back(seg_row(15, 1, 32'h4000_0000, 32'h2000, 32'h2000, 32'h8000_0000,
                                 3'b101));
        script.push_back(fault_typed(32'h0000_1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(setlen_row(16));
        // full page copied from the file
        script.push_back(fault_typed(32'h0000_1000, 1, 0, 3'b111, 32'h200, 0, 13'h1000, 0,
                                     0, 0, 1));
        script.push_back(fault_row(32'h0000_2ABC));     // file data ends mid page, bss follows
        script.push_back(fault_row(32'h0000_3FFF));     // bss only
        script.push_back(fault_typed(32'h0000_4000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3));
        script.push_back(fault_row(32'h0000_0FFF));
        script.push_back(seg_row(1, 1, 32'h1000_0123, 32'h100, 32'h80, 32'h5123, 3'b100));
        script.push_back(fault_row(32'h1000_0122));     // same page, below segment start
        script.push_back(fault_row(32'h1000_0200));     // head zero, copy, tail zero
        script.push_back(seg_row(2, 1, 32'h0000_5800, 32'h1000, 32'h1000, 32'h100, 3'b010));
        script.push_back(fault_row(32'h0000_6000));
        script.push_back(seg_row(3, 1, 32'hFFFF_F800, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 3'b001));
        script.push_back(fault_row(32'hFFFF_FFFF));     // ends past 2^32
        script.push_back(seg_row(4, 1, 32'h2000_0000, 32'h10, 32'h3000, 32'h0, 3'b110));
        script.push_back(fault_row(32'h2000_0FFF));     // file larger than memory
        script.push_back(seg_row(5, 0, 32'h3000_0000, 32'h1000, 32'h1000, 32'h0, 3'b111));
        script.push_back(fault_row(32'h3000_0000));     // not loadable
        script.push_back(seg_row(6, 1, 32'h5000_0010, 32'h0, 32'h0, 32'h1234, 3'b111));
        script.push_back(fault_row(32'h5000_0800));     // zero-size segment, nothing to copy
        script.push_back(seg_row(7, 1, 32'h0000_2000, 32'h100, 32'h100, 32'h0, 3'b000));
        script.push_back(fault_row(32'h0000_2000));     // overlap, lower index wins
        script.push_back(setlen_row(15));
        script.push_back(fault_row(32'h4000_0000));
        script.push_back(setlen_row(31));               // clamps to the table size
        script.push_back(fault_row(32'h4000_1FFF));

        foreach (script[k]) begin
            if (script[k].kind == STEP_SETLEN)
                set_search_len(script[k].setlen);
            else
                issue(script[k]);
        end

        len_plan = '{5'd16, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd16, 5'd1, 5'd8, 5'd16};
        len_plan[PHASES-1] = 5'($urandom_range(31));

        for (phase = 0; phase < PHASES; phase++) begin
            set_search_len(len_plan[phase]);
            quiet = (phase == 6);
            if (phase == 3)
                holds_wanted++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain_replies();
                row = blank_row(STEP_REQ);
                row.body.index     = 4'($urandom);
                row.body.is_load   = 1'($urandom);
                row.body.vaddr     = $urandom;
                row.body.mem_size  = $urandom;
                row.body.file_size = $urandom;
                row.body.file_off  = $urandom;
                row.body.perm      = 3'($urandom);
                row.body.fault_va  = $urandom;
                pick = $urandom_range(99);
                if (pick < 22) begin
                    row.req  = REQ_WRITE;
                    row.body = shape_segment(row.body);
                end else if (pick < 85) begin
                    row.body.fault_va = aim_address();
                end
                issue(row);
            end
        end
        quiet = 1'b0;

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_demand_page_fault_resolver_core passed");
        else
            $display("tb_demand_page_fault_resolver_core failed");
        $finish;
    end

endmodule

// ===== demand_page_fault_resolver_core.f =====
rtl/dpfr_pkg.sv
rtl/dpfr_ctrl.sv
rtl/dpfr_datapath.sv
rtl/demand_page_fault_resolver_core.sv
test/tb_demand_page_fault_resolver_core.sv
